// ===== rtl/core/fpr_pkg.sv =====
// shared constants, types and control struct for the fifo page replacement core
`default_nettype none

package fpr_pkg;

    localparam int MAX_FRAMES = 128;
    localparam int PAGE_BITS  = 8;
    localparam int FAULT_BITS = 16;
    localparam int CFG_BITS   = 8;
    localparam int CFG_RESET  = 128;

    // occupancy runs from zero up to and including the frame total
    localparam int OCC_BITS   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_BITS   = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;

    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (MAX_FRAMES + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic CMD_REF   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_DEC
    } t_state;

    typedef struct packed {
        logic                 shift;
        logic                 write;
        logic [OCC_BITS-1:0]  wr_slot;
        logic [OCC_BITS-1:0]  occupancy;
        logic [PAGE_BITS-1:0] page;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/fpr_cell.sv =====
// one frame of the resident page chain: holds a page, compares it, shifts toward the head
`default_nettype none

module fpr_cell (
    input  wire                            i_clk,
    input  wire  fpr_pkg::t_cell_ctrl      i_ctrl,
    input  wire  [fpr_pkg::OCC_BITS-1:0]   i_index,
    input  wire  [fpr_pkg::PAGE_BITS-1:0]  i_next_page,
    output logic [fpr_pkg::PAGE_BITS-1:0]  o_page,
    output logic                           o_match
);
    import fpr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;
    logic                 r_match;
    logic                 w_live;

    // cells below the occupancy hold resident pages, oldest at index zero
    assign w_live = (i_index < i_ctrl.occupancy);

    always_comb begin
        n_page = r_page;
        if (i_ctrl.write && (i_ctrl.wr_slot == i_index)) begin
            n_page = i_ctrl.page;
        end else if (i_ctrl.shift) begin
            n_page = i_next_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_match <= w_live && (r_page == i_ctrl.page);
    end

    assign o_page  = r_page;
    assign o_match = r_match;

endmodule

`default_nettype wire

// ===== rtl/core/fpr_match_tree.sv =====
// registered first level of the hit reduction: or of each group of cell matches
`default_nettype none

module fpr_match_tree (
    input  wire                          i_clk,
    input  wire  [fpr_pkg::MAX_FRAMES-1:0] i_match,
    output logic [fpr_pkg::GROUPS-1:0]   o_groups
);
    import fpr_pkg::*;

    logic [GROUPS-1:0] r_groups;
    logic [GROUPS-1:0] n_groups;

    always_comb begin
        n_groups = '0;
        for (int g = 0; g < GROUPS; g++) begin
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < MAX_FRAMES) begin
                    n_groups[g] = n_groups[g] | i_match[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_groups <= n_groups;
    end

    assign o_groups = r_groups;

endmodule

`default_nettype wire

// ===== rtl/core/fifo_page_replacement_core.sv =====
// top level of the fifo page replacement core: sequencer, cell chain and result register
`default_nettype none

// Each transaction runs through the sequencer states in order: the
// reference is captured, every cell of the frame chain compares it against
// its page and registers a match, the matches are or-ed in registered groups
// of eight, and the final step folds the groups into the hit, updates the
// chain and loads the result register. That final step waits while an
// earlier result is still stalled. The chain keeps the oldest page in cell
// zero and shifts one cell toward it on every eviction, so the evicted page
// always comes from cell zero. frame_count is written through the config
// channel, which is always ready; write it only between references.
module fifo_page_replacement_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [fpr_pkg::CFG_BITS-1:0]     i_cfg_data,

    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire                              i_in_cmd,
    input  wire  [fpr_pkg::PAGE_BITS-1:0]    i_in_page,

    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_out_hit,
    output logic                             o_out_replaced,
    output logic [fpr_pkg::PAGE_BITS-1:0]    o_out_evicted_page,
    output logic [fpr_pkg::FAULT_BITS-1:0]   o_out_fault_count
);
    import fpr_pkg::*;

    t_state               r_state;
    t_state               n_state;

    logic [CFG_BITS-1:0]  r_frame_count;
    logic [OCC_BITS-1:0]  r_occ;
    logic [OCC_BITS-1:0]  n_occ;
    logic [FAULT_BITS-1:0] r_fault;
    logic [FAULT_BITS-1:0] n_fault;

    logic                 r_cmd;
    logic [PAGE_BITS-1:0] r_page;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic                 r_out_replaced;
    logic [PAGE_BITS-1:0] r_out_evicted;
    logic [FAULT_BITS-1:0] r_out_fault;

    logic                 w_out_free;
    logic                 w_commit;
    logic                 w_hit;
    logic                 w_full;
    logic                 w_miss;
    logic [CMP_BITS-1:0]  w_cfg_ext;
    logic [CMP_BITS-1:0]  w_frames;
    t_cell_ctrl           w_ctrl;

    logic [PAGE_BITS-1:0] w_pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] w_match;
    logic [GROUPS-1:0]    w_groups;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_CMP;
            ST_CMP:  n_state = ST_GRP;
            ST_GRP:  n_state = ST_DEC;
            ST_DEC:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_DEC:  w_commit = w_out_free;
            default: begin
                o_in_stall = 1'b1;
                w_commit   = 1'b0;
            end
        endcase
    end

    // frames in use, with zero taken as one and large values clipped
    assign w_cfg_ext = CMP_BITS'(r_frame_count);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_frames = CMP_BITS'(1);
        end else if (w_cfg_ext > CMP_BITS'(MAX_FRAMES)) begin
            w_frames = CMP_BITS'(MAX_FRAMES);
        end else begin
            w_frames = w_cfg_ext;
        end
    end

    assign w_hit  = |w_groups;
    assign w_full = (CMP_BITS'(r_occ) >= w_frames);
    assign w_miss = (r_cmd == CMD_REF) && !w_hit;

    always_comb begin
        w_ctrl.page      = r_page;
        w_ctrl.occupancy = r_occ;
        w_ctrl.write     = w_commit && w_miss;
        w_ctrl.shift     = w_commit && w_miss && w_full;
        w_ctrl.wr_slot   = w_full ? (r_occ - OCC_BITS'(1)) : r_occ;
    end

    always_comb begin
        n_occ   = r_occ;
        n_fault = r_fault;
        if (r_cmd == CMD_CLEAR) begin
            n_occ   = '0;
            n_fault = '0;
        end else if (w_miss) begin
            if (w_full) begin
                if (r_fault != {FAULT_BITS{1'b1}}) n_fault = r_fault + FAULT_BITS'(1);
            end else begin
                n_occ = r_occ + OCC_BITS'(1);
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_FRAMES; k++) begin : g_cell
            logic [PAGE_BITS-1:0] w_next;
            if (k == MAX_FRAMES - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_link
                assign w_next = w_pages[k + 1];
            end
            fpr_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_index     (OCC_BITS'(k)),
                .i_next_page (w_next),
                .o_page      (w_pages[k]),
                .o_match     (w_match[k])
            );
        end
    endgenerate

    fpr_match_tree u_tree (
        .i_clk    (i_clk),
        .i_match  (w_match),
        .o_groups (w_groups)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frame_count <= CFG_BITS'(CFG_RESET);
            r_occ         <= '0;
            r_fault       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_frame_count <= i_cfg_data;
            if (w_commit) begin
                r_occ   <= n_occ;
                r_fault <= n_fault;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_in_valid) begin
            r_cmd  <= i_in_cmd;
            r_page <= i_in_page;
        end
        if (w_commit) begin
            r_out_hit      <= (r_cmd == CMD_REF) && w_hit;
            r_out_replaced <= w_ctrl.shift;
            r_out_evicted  <= w_ctrl.shift ? w_pages[0] : '0;
            r_out_fault    <= n_fault;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_hit          = r_out_hit;
    assign o_out_replaced     = r_out_replaced;
    assign o_out_evicted_page = r_out_evicted;
    assign o_out_fault_count  = r_out_fault;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_BITS'(r_occ) <= CMP_BITS'(MAX_FRAMES))
        else $error("occupancy above frame total");

    a_hit_xor_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_hit && o_out_replaced))
        else $error("result is both hit and replacement");

    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_cmd == CMD_REF)) |=> (r_fault >= $past(r_fault)))
        else $error("fault counter went down without a clear");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid)
        else $error("committed result not presented");
`endif

endmodule

`default_nettype wire
